### hw/rtl/ttce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_pkg
// Types and constants shared by the text terminal cell engine.
// ----------------------------------------------------------------------------
package ttce_pkg;

  localparam int unsigned DefRows = 24;
  localparam int unsigned DefCols = 80;

  // Command codes.
  localparam logic [2:0] CMD_CHAR  = 3'd0;
  localparam logic [2:0] CMD_TICK  = 3'd1;
  localparam logic [2:0] CMD_SETC  = 3'd2;
  localparam logic [2:0] CMD_WCELL = 3'd3;
  localparam logic [2:0] CMD_SHOW  = 3'd4;
  localparam logic [2:0] CMD_RCELL = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_TEXT_FG = 3'd1;
  localparam logic [2:0] REG_TEXT_BG = 3'd2;
  localparam logic [2:0] REG_SOFTKEY = 3'd3;
  localparam logic [2:0] REG_BLINK   = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [3:0] RST_FG     = 4'd15;
  localparam logic [3:0] RST_BG     = 4'd1;
  localparam logic [5:0] RST_PERIOD = 6'd30;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [4:0] row_index;
    logic [6:0] col_index;
    logic [3:0] cell_foreground;
    logic [3:0] cell_background;
    logic       show_flag;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       cursor_lit;
    logic [7:0] read_char;
    logic [3:0] read_foreground;
    logic [3:0] read_background;
  } out_item_t;

endpackage

### hw/rtl/ttce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ttce_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1920
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### hw/rtl/text_terminal_cell_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cell_engine
// Character cell store and cursor of a text terminal, driven by commands.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Handshake
//  --------  -------------------------------  ---------------------------------
//  command   start, busy, cmd_i               taken when start high, busy low
//  result    result_valid_o, result_o         one cycle strobe, no back-pressure
//  config    psel..pwdata, prdata, pready     APB write on access cycle
//
// A plain item (tick, cursor set, cell write, printable) passes the execute
// state, then the write or read-wait state if it needs one, then done. A tab
// writes one space per pass through the write state. A scroll copies the
// text rows through the single RAM port, reading then writing each cell, and
// blanks the last text row; a form feed or the first item after enabling
// walks the whole store. After reset the store is cleared, with busy high.
// Results cannot be stalled, so the block never waits on its receiver.
//
module text_terminal_cell_engine
  import ttce_pkg::*;
#(
  parameter int unsigned ROWS = DefRows,
  parameter int unsigned COLS = DefCols
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    cmd_i,
  output logic        result_valid_o,
  output out_item_t   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned Cells = ROWS * COLS;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned PW    = $clog2(Cells + 1);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_PUT   = 9'b000000100,
    S_SCRD  = 9'b000001000,
    S_SCWR  = 9'b000010000,
    S_FILL  = 9'b000100000,
    S_RDW   = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_RST   = 9'b100000000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  // Configuration registers.
  logic       enable_q;
  logic [3:0] text_fg_q, text_bg_q;
  logic       softkey_q;
  logic [5:0] period_q;

  // Terminal state.
  logic [4:0] row_q, row_d;
  logic [6:0] col_q, col_d;
  logic       visible_q, visible_d;
  logic       phase_q, phase_d;
  logic [5:0] count_q, count_d;
  logic       seen_q, seen_d;

  // Sequencer working registers.
  in_item_t   cmd_q, cmd_d;
  logic       tab_q, tab_d;
  logic [PW-1:0] ptr_q, ptr_d, end_q, end_d;
  logic [15:0] fill_q, fill_d;
  logic [7:0] rch_q, rch_d;
  logic [3:0] rfg_q, rfg_d, rbg_q, rbg_d;

  // RAM port.
  logic          mem_we;
  logic [PW-1:0] mem_ptr;
  logic [15:0]   mem_wdata, mem_rdata;

  ttce_ram #(
    .Width (16),
    .Depth (Cells)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_ptr[AW-1:0]),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  function automatic logic [PW-1:0] cell_addr(logic [4:0] r, logic [6:0] c);
    return PW'(r * COLS) + PW'(c);
  endfunction

  logic [4:0]  bottom_row;
  logic [15:0] blank_cell;
  logic        cfg_wr;
  logic [7:0]  col_inc;
  logic [5:0]  count_inc;
  logic        in_range;

  assign bottom_row = softkey_q ? 5'(ROWS - 3) : 5'(ROWS - 1);
  assign blank_cell = {CH_SPACE, text_fg_q, text_bg_q};
  assign cfg_wr     = psel && penable && pwrite;
  assign col_inc    = {1'b0, col_q} + 8'd1;
  assign count_inc  = count_q + 6'd1;
  assign in_range   = ({1'b0, cmd_q.row_index} < 6'(ROWS))
                   && ({1'b0, cmd_q.col_index} < 8'(COLS));

  assign pready = 1'b1;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_ENABLE:  prdata[0]   = enable_q;
      REG_TEXT_FG: prdata[3:0] = text_fg_q;
      REG_TEXT_BG: prdata[3:0] = text_bg_q;
      REG_SOFTKEY: prdata[0]   = softkey_q;
      REG_BLINK:   prdata[5:0] = period_q;
      default:     prdata      = '0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    row_d     = row_q;
    col_d     = col_q;
    visible_d = visible_q;
    phase_d   = phase_q;
    count_d   = count_q;
    seen_d    = seen_q;
    cmd_d     = cmd_q;
    tab_d     = tab_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    fill_d    = fill_q;
    rch_d     = rch_q;
    rfg_d     = rfg_q;
    rbg_d     = rbg_q;
    mem_we    = 1'b0;
    mem_ptr   = cell_addr(row_q, col_q);
    mem_wdata = blank_cell;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          rch_d = '0;
          rfg_d = '0;
          rbg_d = '0;
          if (enable_q && !seen_q) begin
            // First item after enable: clear the screen, then run the item.
            seen_d    = 1'b1;
            visible_d = 1'b1;
            phase_d   = 1'b1;
            count_d   = '0;
            row_d     = 5'd1;
            col_d     = '0;
            ptr_d     = '0;
            end_d     = PW'(Cells);
            fill_d    = blank_cell;
            ret_d     = S_EXEC;
            state_d   = S_FILL;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        case (cmd_q.command)
          CMD_CHAR: begin
            if (enable_q) begin
              case (cmd_q.char_code) inside
                CH_CR: col_d = '0;
                CH_LF: begin
                  col_d = '0;
                  if (row_q >= bottom_row) begin
                    row_d   = bottom_row;
                    ptr_d   = PW'(COLS);
                    end_d   = cell_addr(bottom_row, 7'd0);
                    fill_d  = blank_cell;
                    ret_d   = S_DONE;
                    state_d = (bottom_row == 5'd1) ? S_FILL : S_SCRD;
                    if (bottom_row == 5'd1) begin
                      end_d = PW'(2 * COLS);
                    end
                  end else begin
                    row_d = row_q + 5'd1;
                  end
                end
                CH_BS, CH_DEL: begin
                  if (col_q != '0) begin
                    col_d = col_q - 7'd1;
                  end else if (row_q > 5'd1) begin
                    row_d = row_q - 5'd1;
                    col_d = 7'(COLS - 1);
                  end
                  mem_we  = 1'b1;
                  mem_ptr = cell_addr(row_d, col_d);
                end
                CH_TAB: begin
                  tab_d   = 1'b1;
                  state_d = S_PUT;
                end
                CH_FF: begin
                  row_d   = 5'd1;
                  col_d   = '0;
                  ptr_d   = '0;
                  end_d   = PW'(Cells);
                  fill_d  = blank_cell;
                  ret_d   = S_DONE;
                  state_d = S_FILL;
                end
                default: begin
                  if (cmd_q.char_code >= CH_SPACE) begin
                    tab_d   = 1'b0;
                    state_d = S_PUT;
                  end
                end
              endcase
            end
          end
          CMD_TICK: begin
            if (enable_q && visible_q) begin
              count_d = count_inc;
              if (count_inc >= period_q) begin
                count_d = '0;
                phase_d = !phase_q;
              end
            end
          end
          CMD_SETC: begin
            row_d = cmd_q.row_index;
            if (row_d < 5'd1) begin
              row_d = 5'd1;
            end
            if (row_d > bottom_row) begin
              row_d = bottom_row;
            end
            col_d = ({1'b0, cmd_q.col_index} >= 8'(COLS)) ? 7'(COLS - 1)
                                                          : cmd_q.col_index;
            phase_d = 1'b1;
            count_d = '0;
          end
          CMD_WCELL: begin
            if (enable_q && in_range) begin
              mem_we    = 1'b1;
              mem_ptr   = cell_addr(cmd_q.row_index, cmd_q.col_index);
              mem_wdata = {cmd_q.char_code, cmd_q.cell_foreground,
                           cmd_q.cell_background};
            end
          end
          CMD_SHOW: begin
            visible_d = cmd_q.show_flag;
            phase_d   = 1'b1;
            count_d   = '0;
          end
          CMD_RCELL: begin
            if (in_range) begin
              mem_ptr = cell_addr(cmd_q.row_index, cmd_q.col_index);
              state_d = S_RDW;
            end else begin
              rch_d = CH_SPACE;
              rfg_d = text_fg_q;
              rbg_d = text_bg_q;
            end
          end
          default: ;
        endcase
      end

      S_PUT: begin
        // Writes one character at the cursor and advances it.
        mem_we    = 1'b1;
        mem_wdata = {tab_q ? CH_SPACE : cmd_q.char_code, text_fg_q, text_bg_q};
        state_d   = S_DONE;
        if (col_inc >= 8'(COLS)) begin
          col_d = '0;
          if (row_q >= bottom_row) begin
            row_d   = bottom_row;
            ptr_d   = PW'(COLS);
            end_d   = cell_addr(bottom_row, 7'd0);
            fill_d  = blank_cell;
            ret_d   = S_DONE;
            state_d = (bottom_row == 5'd1) ? S_FILL : S_SCRD;
            if (bottom_row == 5'd1) begin
              end_d = PW'(2 * COLS);
            end
          end else begin
            row_d = row_q + 5'd1;
          end
        end else begin
          col_d = col_inc[6:0];
          if (tab_q && (col_inc[2:0] != 3'd0)) begin
            state_d = S_PUT;
          end
        end
      end

      S_SCRD: begin
        mem_ptr = ptr_q + PW'(COLS);
        state_d = S_SCWR;
      end

      S_SCWR: begin
        mem_we    = 1'b1;
        mem_ptr   = ptr_q;
        mem_wdata = mem_rdata;
        ptr_d     = ptr_q + PW'(1);
        if (ptr_d == end_q) begin
          end_d   = end_q + PW'(COLS);
          state_d = S_FILL;
        end else begin
          state_d = S_SCRD;
        end
      end

      S_FILL, S_RST: begin
        mem_we    = 1'b1;
        mem_ptr   = ptr_q;
        mem_wdata = fill_q;
        ptr_d     = ptr_q + PW'(1);
        if (ptr_d == end_q) begin
          state_d = ret_q;
        end
      end

      S_RDW: begin
        rch_d   = mem_rdata[15:8];
        rfg_d   = mem_rdata[7:4];
        rbg_d   = mem_rdata[3:0];
        state_d = S_DONE;
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    // Register writes that touch terminal state. Disabling forgets that the
    // terminal was seen enabled; showing the softkey bar pulls the cursor up
    // onto the shortened text area.
    if (cfg_wr) begin
      if ((paddr[4:2] == REG_ENABLE) && !pwdata[0]) begin
        seen_d = 1'b0;
      end
      if ((paddr[4:2] == REG_SOFTKEY) && pwdata[0] && (row_q > 5'(ROWS - 3))) begin
        row_d = 5'(ROWS - 3);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RST;
      ret_q     <= S_IDLE;
      enable_q  <= 1'b0;
      text_fg_q <= RST_FG;
      text_bg_q <= RST_BG;
      softkey_q <= 1'b0;
      period_q  <= RST_PERIOD;
      row_q     <= 5'd1;
      col_q     <= '0;
      visible_q <= 1'b1;
      phase_q   <= 1'b1;
      count_q   <= '0;
      seen_q    <= 1'b0;
      tab_q     <= 1'b0;
      ptr_q     <= '0;
      end_q     <= PW'(Cells);
      fill_q    <= {CH_SPACE, RST_FG, RST_BG};
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      row_q     <= row_d;
      col_q     <= col_d;
      visible_q <= visible_d;
      phase_q   <= phase_d;
      count_q   <= count_d;
      seen_q    <= seen_d;
      tab_q     <= tab_d;
      ptr_q     <= ptr_d;
      end_q     <= end_d;
      fill_q    <= fill_d;
      // The user must write configuration only while the sequencer is idle; the block itself does not enforce this.
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_ENABLE:  enable_q  <= pwdata[0];
          REG_TEXT_FG: text_fg_q <= pwdata[3:0];
          REG_TEXT_BG: text_bg_q <= pwdata[3:0];
          REG_SOFTKEY: softkey_q <= pwdata[0];
          REG_BLINK:   period_q  <= pwdata[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rch_q <= rch_d;
    rfg_q <= rfg_d;
    rbg_q <= rbg_d;
  end

  assign result_valid_o            = (state_q == S_DONE);
  assign result_o.cursor_row       = row_q;
  assign result_o.cursor_col       = col_q;
  assign result_o.cursor_lit       = enable_q && visible_q && phase_q;
  assign result_o.read_char        = rch_q;
  assign result_o.read_foreground  = rfg_q;
  assign result_o.read_background  = rbg_q;

endmodule

### tb/text_terminal_cell_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cell_engine_tb
// Self-checking bench for the text terminal cell engine. Commands are driven
// through the start/busy handshake and the registers are programmed through
// the APB port between phases. A scoreboard class keeps its own copy of the
// cell store, cursor and blink state, predicts one result per accepted item
// and compares every result strobe field by field against it.
// ----------------------------------------------------------------------------
module text_terminal_cell_engine_tb;
  import ttce_pkg::*;

  localparam int NROWS = DefRows;
  localparam int NCOLS = DefCols;
  // Command codes beyond the defined set: the engine must leave all state alone.
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 50000;

  // Scoreboard: predicts the cursor, blink and store for each accepted item
  // and holds the results that are still to come, oldest first.
  class cell_scoreboard;
    logic [15:0] cells [NROWS*NCOLS];
    int          cur_row, cur_col, blink_cnt;
    bit          visible, phase_on, enable_seen, enabled, softkey;
    logic [3:0]  text_fg, text_bg;
    logic [5:0]  period;
    out_item_t   awaited[$];
    int          errors, checked;

    function new();
      enabled = 0; text_fg = RST_FG; text_bg = RST_BG; softkey = 0;
      period = RST_PERIOD; cur_row = 1; cur_col = 0; visible = 1;
      phase_on = 1; blink_cnt = 0; enable_seen = 0; errors = 0; checked = 0;
      fill_blank(RST_FG, RST_BG);
    endfunction

    function int bottom_row();
      return softkey ? NROWS - 3 : NROWS - 1;
    endfunction

    function void fill_blank(logic [3:0] fg, logic [3:0] bg);
      foreach (cells[i]) cells[i] = {CH_SPACE, fg, bg};
    endfunction

    function void put_cell(int r, int c, logic [15:0] v);
      if (r < NROWS && c < NCOLS) cells[r*NCOLS + c] = v;
    endfunction

    function void clamp_cursor();
      if (cur_row < 1) cur_row = 1;
      if (cur_row > bottom_row()) cur_row = bottom_row();
      if (cur_col >= NCOLS) cur_col = NCOLS - 1;
    endfunction

    function void new_line();
      int lr;
      lr = bottom_row();
      cur_col = 0;
      cur_row++;
      if (cur_row > lr) begin
        for (int r = 1; r < lr; r++)
          for (int c = 0; c < NCOLS; c++) cells[r*NCOLS + c] = cells[(r+1)*NCOLS + c];
        for (int c = 0; c < NCOLS; c++) put_cell(lr, c, {CH_SPACE, text_fg, text_bg});
        cur_row = lr;
        cur_col = 0;
      end
    endfunction

    function void put_char(logic [7:0] ch);
      put_cell(cur_row, cur_col, {ch, text_fg, text_bg});
      cur_col++;
      if (cur_col >= NCOLS) new_line();
    endfunction

    function void char_byte(logic [7:0] ch);
      case (ch)
        CH_CR: cur_col = 0;
        CH_LF: new_line();
        CH_BS, CH_DEL: begin
          if (cur_col > 0) cur_col--;
          else if (cur_row > 1) begin
            cur_row--;
            cur_col = NCOLS - 1;
          end
          put_cell(cur_row, cur_col, {CH_SPACE, text_fg, text_bg});
        end
        CH_TAB: begin
          do put_char(CH_SPACE); while ((cur_col & 7) != 0);
        end
        CH_FF: begin
          fill_blank(text_fg, text_bg);
          cur_row = 1;
          cur_col = 0;
        end
        default: if (ch >= CH_SPACE) put_char(ch);
      endcase
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_ENABLE: begin
          enabled = v[0];
          if (!v[0]) enable_seen = 0;
        end
        REG_TEXT_FG: text_fg = v[3:0];
        REG_TEXT_BG: text_bg = v[3:0];
        REG_SOFTKEY: if (v[0] != softkey) begin
          softkey = v[0];
          clamp_cursor();
        end
        REG_BLINK: period = v[5:0];
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_item(in_item_t it);
      out_item_t r;
      r = '0;
      if (enabled && !enable_seen) begin
        enable_seen = 1; visible = 1; phase_on = 1; blink_cnt = 0;
        fill_blank(text_fg, text_bg);
        cur_row = 1; cur_col = 0;
      end
      case (it.command)
        CMD_CHAR: if (enabled) char_byte(it.char_code);
        CMD_TICK: if (enabled && visible) begin
          blink_cnt = (blink_cnt + 1) & 63;
          if (blink_cnt >= period) begin
            blink_cnt = 0;
            phase_on = !phase_on;
          end
        end
        CMD_SETC: begin
          cur_row = it.row_index; cur_col = it.col_index;
          clamp_cursor();
          phase_on = 1; blink_cnt = 0;
        end
        CMD_WCELL: if (enabled)
          put_cell(it.row_index, it.col_index,
                   {it.char_code, it.cell_foreground, it.cell_background});
        CMD_SHOW: begin
          visible = it.show_flag;
          phase_on = 1; blink_cnt = 0;
        end
        CMD_RCELL: begin
          if (it.row_index < NROWS && it.col_index < NCOLS)
            {r.read_char, r.read_foreground, r.read_background} =
              cells[it.row_index*NCOLS + it.col_index];
          else begin
            r.read_char = CH_SPACE; r.read_foreground = text_fg; r.read_background = text_bg;
          end
        end
        default: ;
      endcase
      r.cursor_row = cur_row[4:0];
      r.cursor_col = cur_col[6:0];
      r.cursor_lit = enabled && visible && phase_on;
      awaited.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (got.cursor_row !== e.cursor_row)
        $display("%0t: cursor_row expected %0d actual %0d", $time, e.cursor_row, got.cursor_row);
      if (got.cursor_col !== e.cursor_col)
        $display("%0t: cursor_col expected %0d actual %0d", $time, e.cursor_col, got.cursor_col);
      if (got.cursor_lit !== e.cursor_lit)
        $display("%0t: cursor_lit expected %0b actual %0b", $time, e.cursor_lit, got.cursor_lit);
      if (got.read_char !== e.read_char)
        $display("%0t: read_char expected %h actual %h", $time, e.read_char, got.read_char);
      if (got.read_foreground !== e.read_foreground)
        $display("%0t: read_foreground expected %0d actual %0d", $time,
                 e.read_foreground, got.read_foreground);
      if (got.read_background !== e.read_background)
        $display("%0t: read_background expected %0d actual %0d", $time,
                 e.read_background, got.read_background);
      if (got !== e) errors++;
    endfunction
  endclass

  logic        clk_i, rst_ni, start, busy, result_valid_o, pready;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  in_item_t    cmd_i;
  out_item_t   result_o;

  cell_scoreboard sb = new();
  int idle_pct;      // chance, in percent, of a gap before each item
  int sent_items;
  int quiet_cycles;

  text_terminal_cell_engine u_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Everything is sampled at the rising edge. The item is noted before the
  // result is checked so that the queue is in order whatever the latency.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_item(cmd_i);
      if (result_valid_o) sb.check_result(result_o);
    end
  end

  // Watchdog: any stretch this long with nothing accepted and no result means a hang.
  // The post-reset clear and the longest scroll are well inside the limit.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.awaited.size());
      $display("text_terminal_cell_engine_tb: FAIL");
      $finish;
    end
  end

  // Presents one item and holds it until the engine takes it. Start is left
  // high so that back-to-back items need no second assignment in one step.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= it;
    do @(posedge clk_i); while (busy);
    sent_items++;
  endtask

  // Waits for every expected result, then for the engine to go idle, so
  // that a register write cannot land in the middle of a scroll or clear.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  function automatic in_item_t mk(logic [2:0] c, logic [7:0] ch = 8'h00,
                                  logic [4:0] r = 0, logic [6:0] col = 0,
                                  logic [3:0] fg = 0, logic [3:0] bg = 0, bit sh = 0);
    in_item_t it;
    it = {c, ch, r, col, fg, bg, sh};
    return it;
  endfunction

  // Random item: text more often than any other command, with occasional line feeds and rare clears
  // because scrolls and clears walk the whole store.
  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    it = in_item_t'($urandom);
    pick = $urandom_range(999);
    if (pick < 470) begin
      it.command = CMD_CHAR;
      pick = $urandom_range(99);
      if (pick < 3) it.char_code = CH_LF;
      else if (pick < 6) it.char_code = CH_CR;
      else if (pick < 10) it.char_code = CH_TAB;
      else if (pick < 14) it.char_code = ($urandom_range(1)) ? CH_BS : CH_DEL;
      else if (pick < 18) it.char_code = 8'($urandom_range(31));
      else if (pick == 18 && $urandom_range(3) == 0) it.char_code = CH_FF;
      else if (it.char_code == CH_FF) it.char_code = 8'h41;
    end else if (pick < 680) it.command = CMD_TICK;
    else if (pick < 760) it.command = CMD_SETC;
    else if (pick < 840) it.command = CMD_WCELL;
    else if (pick < 880) it.command = CMD_SHOW;
    else if (pick < 985) it.command = CMD_RCELL;
    else it.command = ($urandom_range(1)) ? CMD_SPARE6 : CMD_SPARE7;
    // Keep most cell accesses inside the store; the rest take random indexes that may fall outside it.
    if (it.command inside {CMD_WCELL, CMD_RCELL} && $urandom_range(9) != 0) begin
      it.row_index = 5'($urandom_range(NROWS - 1));
      it.col_index = 7'($urandom_range(NCOLS - 1));
    end
    return it;
  endfunction

  initial begin
    start = 0; cmd_i = '0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    idle_pct = 0; sent_items = 0; quiet_cycles = 0;
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed part. While disabled only set cursor, show cursor and read cell act.
    send_item(mk(CMD_TICK));
    send_item(mk(CMD_WCELL, 8'h55, 5'd3, 7'd3, 4'd2, 4'd3));
    send_item(mk(CMD_SETC, 8'h00, 5'd0, 7'd0));
    send_item(mk(CMD_SHOW, 8'h00, 5'd0, 7'd0, 4'd0, 4'd0, 1'b0));
    send_item(mk(CMD_RCELL, 8'h00, 5'd3, 7'd3));
    drain();
    write_reg(REG_TEXT_FG, 32'd0);
    write_reg(REG_TEXT_BG, 32'd15);
    write_reg(REG_BLINK, 32'd1);
    write_reg(REG_ENABLE, 32'd1);
    // First item after enabling clears the store and shows the cursor.
    send_item(mk(CMD_CHAR, 8'h41));
    send_item(mk(CMD_CHAR, 8'hFF));
    send_item(mk(CMD_CHAR, 8'h01));
    send_item(mk(CMD_CHAR, CH_TAB));
    send_item(mk(CMD_CHAR, CH_CR));
    send_item(mk(CMD_CHAR, CH_BS));    // backspace at home blanks row 1 col 0
    send_item(mk(CMD_CHAR, CH_DEL));
    send_item(mk(CMD_SETC, 8'h00, 5'd31, 7'd127));
    send_item(mk(CMD_CHAR, CH_LF));    // line feed on the last row scrolls
    send_item(mk(CMD_SETC, 8'h00, 5'd5, 7'd76));
    send_item(mk(CMD_CHAR, CH_TAB));   // tab that wraps stops at column 0
    send_item(mk(CMD_WCELL, 8'hA5, 5'd31, 7'd127, 4'd15, 4'd15));
    send_item(mk(CMD_WCELL, 8'h7E, 5'd23, 7'd79, 4'd9, 4'd6));
    send_item(mk(CMD_RCELL, 8'h00, 5'd23, 7'd79));
    send_item(mk(CMD_RCELL, 8'h00, 5'd24, 7'd80));
    send_item(mk(CMD_TICK));
    send_item(mk(CMD_SHOW, 8'h00, 5'd0, 7'd0, 4'd0, 4'd0, 1'b0));
    send_item(mk(CMD_TICK));           // hidden cursor ignores ticks
    send_item(mk(CMD_SHOW, 8'h00, 5'd0, 7'd0, 4'd0, 4'd0, 1'b1));
    send_item(mk(CMD_SPARE6));
    send_item(mk(CMD_SPARE7));
    send_item(mk(CMD_CHAR, CH_FF));

    // Random phases, with the registers moved between them. The sender
    // pauses at every drain until all results are home.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(REG_SOFTKEY, 32'd1);
          write_reg(REG_BLINK, 32'd63);
        end
        2: begin
          write_reg(REG_BLINK, 32'd0);   // a zero period behaves as one
          write_reg(REG_TEXT_FG, 32'd15);
          write_reg(REG_TEXT_BG, 32'd0);
        end
        3: begin
          write_reg(REG_ENABLE, 32'd0);  // a short disabled stretch
          for (int k = 0; k < 10; k++) send_item(random_item());
          drain();
          write_reg(REG_ENABLE, 32'd1);
          write_reg(REG_SOFTKEY, 32'd0);
        end
        default: begin
          write_reg(REG_TEXT_FG, $urandom_range(15));
          write_reg(REG_TEXT_BG, $urandom_range(15));
          write_reg(REG_BLINK, $urandom_range(1, 6));
          write_reg(REG_SOFTKEY, $urandom_range(1));
        end
      endcase
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 75;
        2: idle_pct = 0;
        default: idle_pct = 33;
      endcase
      for (int k = 0; k < 190; k++) send_item(random_item());
    end

    drain();
    repeat (100) @(posedge clk_i);
    $display("Run covered %0d items and %0d checked results over eight phases,",
             sent_items, sb.checked);
    $display("with scrolls, clears, softkey changes, blink periods 0 to 63 and idle gaps.");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("text_terminal_cell_engine_tb: PASS");
    end else begin
      $display("text_terminal_cell_engine_tb: FAIL");
    end
    $finish;
  end

endmodule

### text_terminal_cell_engine.f
hw/rtl/ttce_pkg.sv
hw/rtl/ttce_ram.sv
hw/rtl/text_terminal_cell_engine.sv
tb/text_terminal_cell_engine_tb.sv
